/* sv/tcon_pkg.sv */
// Shared types, field widths and codes for the text console cursor engine.
// No dependencies; every other file of the block depends on this package.

package tcon_pkg;

   // Default geometry of the console.
   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 8;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Field widths of the channels and the register port.
   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = 11;
   localparam int POS_W     = 11;
   localparam int CELL_W    = 16;
   localparam int ATTR_W    = 8;
   localparam int PCOL_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Character codes with special handling.
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTECTED = 1'd1;
   localparam logic [ATTR_W-1:0]    RESET_ATTRIBUTE = 8'h0F;
   localparam logic [PCOL_W-1:0]    RESET_PROTECTED = 7'd10;

   // Command classes produced by the front.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PRINT,
      CMD_BACKSPACE,
      CMD_TAB,
      CMD_CR,
      CMD_LF,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic [ATTR_W-1:0] attribute;
      logic [PCOL_W-1:0] protected_column;
   } cfg_type;

endpackage

/* sv/tcon_req_if.sv */
// Request channel of the console: valid/ready handshake and request fields.
// Depends on tcon_pkg for the field widths.

interface tcon_req_if;
   import tcon_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CHAR_W-1:0] char_code;
   logic [IDX_W-1:0]  cell_index;

   modport source (output valid, output operation, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input operation, input char_code, input cell_index,
                   output ready);
endinterface

/* sv/tcon_rsp_if.sv */
// Response channel of the console: valid/ready handshake and result fields.
// Depends on tcon_pkg for the field widths.

interface tcon_rsp_if;
   import tcon_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_position;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cursor_position, output cell_value, input ready);
   modport sink   (input valid, input cursor_position, input cell_value, output ready);
endinterface

/* sv/tcon_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on tcon_pkg only for its default width and depth.

module tcon_ram #(
   parameter int  WIDTH = tcon_pkg::CELL_W,
   parameter int  DEPTH = tcon_pkg::COLUMNS_DEF * tcon_pkg::ROWS_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write first port, read second port; read data is registered and appears in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* sv/tcon_front.sv */
// Front of the console: accepts requests and classifies them into commands.
// Depends on tcon_pkg and tcon_req_if; feeds tcon_queue.

module tcon_front (
   tcon_req_if.sink             req_bus,
   input  logic                 init_busy,
   input  tcon_pkg::q_stat_type q_stat,
   output logic                 push,
   output tcon_pkg::cmd_type    push_cmd
);
   import tcon_pkg::*;

   // A request is taken whenever the queue has room and the screen is initialized.
   assign req_bus.ready = !q_stat.full && !init_busy;
   assign push          = req_bus.valid && req_bus.ready;

   // Decode operation and character into one command class.
   always_comb begin
      push_cmd.kind       = CMD_NOP;
      push_cmd.char_code  = req_bus.char_code;
      push_cmd.cell_index = req_bus.cell_index;
      unique case (req_bus.operation)
         OP_PUT: begin
            unique case (req_bus.char_code)
               CHAR_BACKSPACE: push_cmd.kind = CMD_BACKSPACE;
               CHAR_TAB:       push_cmd.kind = CMD_TAB;
               CHAR_CR:        push_cmd.kind = CMD_CR;
               CHAR_LF:        push_cmd.kind = CMD_LF;
               default: begin
                  // Other control codes are dropped.
                  push_cmd.kind = (req_bus.char_code >= CHAR_SPACE) ? CMD_PRINT : CMD_NOP;
               end
            endcase
         end
         OP_READ:  push_cmd.kind = CMD_READ;
         OP_CLEAR: push_cmd.kind = CMD_CLEAR;
         default:  push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

/* sv/tcon_queue.sv */
// Short command queue between the front and the back of the console.
// Depends on tcon_pkg for the command type.

module tcon_queue #(
   parameter int DEPTH = tcon_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcon_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output tcon_pkg::cmd_type    head,
   output tcon_pkg::q_stat_type q_stat
);
   import tcon_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

/* sv/tcon_back.sv */
// Back of the console: executes commands on the cursor and the cell RAM.
// Depends on tcon_pkg and tcon_rsp_if; drives the ports of one tcon_ram.

module tcon_back #(
   parameter int  COLUMNS  = tcon_pkg::COLUMNS_DEF,
   parameter int  ROWS     = tcon_pkg::ROWS_DEF,
   parameter int  TAB_STOP = tcon_pkg::TAB_STOP_DEF,
   localparam int CELLS    = COLUMNS * ROWS,
   localparam int AW       = $clog2(CELLS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcon_pkg::cfg_type             cfg,
   input  tcon_pkg::q_stat_type          q_stat,
   input  tcon_pkg::cmd_type             q_head,
   output logic                          q_pop,
   output logic                          init_busy,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [tcon_pkg::CELL_W-1:0]   ram_wr_data,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [tcon_pkg::CELL_W-1:0]   ram_rd_data,
   tcon_rsp_if.source                    rsp_bus
);
   import tcon_pkg::*;

   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(COLUMNS);
   localparam int RW  = $clog2(ROWS);
   localparam int PW  = $clog2(TAB_STOP);
   localparam int TW  = $clog2(COLUMNS + TAB_STOP);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FILL
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     phys_here_ff, phys_here_in;
   logic [AW-1:0]     phys_idx_ff, phys_idx_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [AW-1:0]     fill_addr_ff, fill_addr_in;
   logic [AW1-1:0]    fill_left_ff, fill_left_in;
   logic [CELL_W-1:0] fill_val_ff, fill_val_in;
   logic              fill_report_ff, fill_report_in;
   logic              init_busy_ff, init_busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;

   logic [TW-1:0]     col_t;
   logic              new_row;
   logic              finish;
   logic [CELL_W-1:0] finish_value;
   logic [CELL_W-1:0] blank;
   logic [AW1-1:0]    here_sum;
   logic [AW1-1:0]    idx_sum;
   logic              rsp_free;

   // Logical to physical address: rows rotate by base_ff, so wrap once at the end.
   function automatic logic [AW-1:0] wrap_addr(input logic [AW1-1:0] sum);
      logic [AW1-1:0] adj;
      adj = sum - AW1'(CELLS);
      return (sum >= AW1'(CELLS)) ? adj[AW-1:0] : sum[AW-1:0];
   endfunction

   assign blank = {cfg.attribute, CHAR_SPACE};

   // Command sequencer: pop, execute, then read wait or a fill sweep.
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      phase_in       = phase_ff;
      base_in        = base_ff;
      phys_here_in   = phys_here_ff;
      phys_idx_in    = phys_idx_ff;
      idx_ok_in      = idx_ok_ff;
      fill_addr_in   = fill_addr_ff;
      fill_left_in   = fill_left_ff;
      fill_val_in    = fill_val_ff;
      fill_report_in = fill_report_ff;
      init_busy_in   = init_busy_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_value_in   = rsp_value_ff;
      q_pop          = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = fill_addr_ff;
      ram_wr_data    = fill_val_ff;
      col_t          = TW'(col_ff);
      new_row        = 1'b0;
      finish         = 1'b0;
      finish_value   = '0;
      rsp_free       = !rsp_valid_ff || rsp_bus.ready;
      here_sum       = AW1'(row_ff) * AW1'(COLUMNS) + AW1'(col_ff) + AW1'(base_ff);
      idx_sum        = AW1'(q_head.cell_index) + AW1'(base_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next command once the response register is free.
            if (!q_stat.empty && rsp_free) begin
               q_pop        = 1'b1;
               cmd_in       = q_head;
               phys_here_in = wrap_addr(here_sum);
               phys_idx_in  = wrap_addr(idx_sum);
               idx_ok_in    = 32'(q_head.cell_index) < 32'(CELLS);
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cmd_ff.kind)
               CMD_PRINT: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = phys_here_ff;
                  ram_wr_data = {cfg.attribute, cmd_ff.char_code};
                  col_t       = TW'(col_ff) + 1'b1;
                  phase_in    = (phase_ff == PW'(TAB_STOP - 1)) ? '0 : phase_ff + 1'b1;
               end
               CMD_BACKSPACE: begin
                  // Refused at the left edge and at the protected column.
                  if (col_ff != '0 && PCOL_W'(col_ff) != cfg.protected_column) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = phys_here_ff - 1'b1;
                     ram_wr_data = blank;
                     col_t       = TW'(col_ff) - 1'b1;
                     phase_in    = (phase_ff == '0) ? PW'(TAB_STOP - 1) : phase_ff - 1'b1;
                  end
               end
               CMD_TAB: begin
                  col_t    = TW'(col_ff) + TW'(TAB_STOP) - TW'(phase_ff);
                  phase_in = '0;
               end
               CMD_CR: begin
                  col_t    = '0;
                  phase_in = '0;
               end
               CMD_LF: begin
                  new_row = 1'b1;
               end
               CMD_READ: begin
                  // An address off the screen reads as zero.
                  if (idx_ok_ff) begin
                     state_in = ST_READ;
                  end
               end
               CMD_CLEAR: begin
                  col_t          = '0;
                  phase_in       = '0;
                  row_in         = '0;
                  base_in        = '0;
                  fill_addr_in   = '0;
                  fill_left_in   = AW1'(CELLS);
                  fill_val_in    = blank;
                  fill_report_in = 1'b1;
                  state_in       = ST_FILL;
               end
               default: begin
               end
            endcase

            // Wrap at the right edge; scrolling rotates the base and blanks one row.
            if (col_t >= TW'(COLUMNS)) begin
               new_row = 1'b1;
            end
            if (new_row) begin
               col_in   = '0;
               phase_in = '0;
               if (row_ff == RW'(ROWS - 1)) begin
                  base_in        = wrap_addr(AW1'(base_ff) + AW1'(COLUMNS));
                  fill_addr_in   = base_ff;
                  fill_left_in   = AW1'(COLUMNS);
                  fill_val_in    = blank;
                  fill_report_in = 1'b1;
                  state_in       = ST_FILL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = CW'(col_t);
            end
            finish = (state_in == ST_IDLE);
         end

         ST_READ: begin
            finish       = 1'b1;
            finish_value = ram_rd_data;
            state_in     = ST_IDLE;
         end

         ST_FILL: begin
            // One cell per cycle; the reset sweep ends without a response.
            ram_wr_en    = 1'b1;
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == AW1'(1)) begin
               state_in = ST_IDLE;
               if (fill_report_ff) begin
                  finish = 1'b1;
               end else begin
                  init_busy_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the response register with the cursor after this command.
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = POS_W'(AW'(row_in) * AW'(COLUMNS) + AW'(col_in));
         rsp_value_in = finish_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         col_ff         <= '0;
         row_ff         <= '0;
         phase_ff       <= '0;
         base_ff        <= '0;
         fill_addr_ff   <= '0;
         fill_left_ff   <= AW1'(CELLS);
         fill_val_ff    <= {RESET_ATTRIBUTE, CHAR_SPACE};
         fill_report_ff <= 1'b0;
         init_busy_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         phase_ff       <= phase_in;
         base_ff        <= base_in;
         fill_addr_ff   <= fill_addr_in;
         fill_left_ff   <= fill_left_in;
         fill_val_ff    <= fill_val_in;
         fill_report_ff <= fill_report_in;
         init_busy_ff   <= init_busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      phys_here_ff <= phys_here_in;
      phys_idx_ff  <= phys_idx_in;
      idx_ok_ff    <= idx_ok_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign init_busy               = init_busy_ff;
   assign ram_rd_addr             = phys_idx_ff;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cursor_position = rsp_pos_ff;
   assign rsp_bus.cell_value      = rsp_value_ff;

endmodule

/* sv/text_console_cursor_engine.sv */
// Top level of the text console: register file, front, queue, back and cell RAM.
// Depends on tcon_pkg, tcon_req_if, tcon_rsp_if, tcon_ram, tcon_front, tcon_queue, tcon_back.
//
//   Port group   Direction  Handshake         Carries
//   req_bus      in         valid/ready       operation, char_code, cell_index
//   rsp_bus      out        valid/ready       cursor_position, cell_value
//   csr_*        in         write enable      register index and write data
//
// In the back each request passes an issue step (ST_IDLE) and an execute step (ST_EXEC); a
// read adds ST_READ because of the registered RAM read. A scroll sweeps COLUMNS cells and a
// clear CELLS cells in ST_FILL, one cell per cycle through the single RAM write port.
// After reset all CELLS cells (2000 by default) of the RAM are swept to blanks with
// req_bus.ready low; register writes are taken during the sweep.
// Up to two requests wait in the queue while the back is busy or a response stalls.

module text_console_cursor_engine #(
   parameter int COLUMNS  = tcon_pkg::COLUMNS_DEF,
   parameter int ROWS     = tcon_pkg::ROWS_DEF,
   parameter int TAB_STOP = tcon_pkg::TAB_STOP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   tcon_req_if.sink                       req_bus,
   tcon_rsp_if.source                     rsp_bus,
   input  logic                           csr_write_enable,
   input  logic [tcon_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcon_pkg::CSR_DAT_W-1:0] csr_write_data
);
   import tcon_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   cfg_type           cfg_ff, cfg_in;
   q_stat_type        q_stat;
   cmd_type           push_cmd;
   cmd_type           q_head;
   logic              push;
   logic              q_pop;
   logic              init_busy;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ATTRIBUTE: cfg_in.attribute        = csr_write_data[ATTR_W-1:0];
            CSR_PROTECTED: cfg_in.protected_column = csr_write_data[PCOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attribute        <= RESET_ATTRIBUTE;
         cfg_ff.protected_column <= RESET_PROTECTED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcon_front u_front (
      .req_bus   (req_bus),
      .init_busy (init_busy),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   tcon_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .q_stat   (q_stat)
   );

   tcon_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .init_busy   (init_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_bus     (rsp_bus)
   );

   tcon_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* sv/tcon_checker.sv */
// Port-level checks for the text console, attached to the top level by bind.
// Depends on tcon_pkg for field widths and the queue depth.

module tcon_props (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tcon_pkg::POS_W-1:0]  rsp_cursor_position,
   input logic [tcon_pkg::CELL_W-1:0] rsp_cell_value
);
   import tcon_pkg::*;

   localparam int OUT_W = $clog2(QUEUE_DEPTH + 3);

   logic [OUT_W-1:0] outstanding_ff, outstanding_in;
   logic             req_take;
   logic             rsp_take;

   // Count requests that have not yet been answered.
   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // Reset drops any pending response.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The screen sweep after reset holds off requests.
   a_init_stall: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready during the reset sweep");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
                                   && $stable(rsp_cell_value))
      else $error("stalled response changed");

   // Every response answers an earlier request.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response without a pending request");

endmodule

bind text_console_cursor_engine tcon_props u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_cursor_position (rsp_bus.cursor_position),
   .rsp_cell_value      (rsp_bus.cell_value)
);

/* tb/tcon_checker.sv */
// Response checker of the text console: watches the request, response and register ports.
// Keeps its own copy of the cursor, the cell store and the registers; depends on tcon_pkg,
// tcon_req_if and tcon_rsp_if.

module tcon_checker #(
   parameter int COLUMNS  = tcon_pkg::COLUMNS_DEF,
   parameter int ROWS     = tcon_pkg::ROWS_DEF,
   parameter int TAB_STOP = tcon_pkg::TAB_STOP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   tcon_req_if                            req_mon,
   tcon_rsp_if                            rsp_mon,
   input  logic                           csr_write_enable,
   input  logic [tcon_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcon_pkg::CSR_DAT_W-1:0] csr_write_data,
   output int unsigned                    pending_results,
   output int unsigned                    failures
);
   import tcon_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct {
      logic [POS_W-1:0]  position;
      logic [CELL_W-1:0] value;
   } console_result_type;

   // Shadow copy of the console state.
   logic [CELL_W-1:0] screen_model [0:CELLS-1];
   int unsigned       cursor_col;
   int unsigned       cursor_row;
   logic [ATTR_W-1:0] text_attr;
   logic [PCOL_W-1:0] guard_col;

   console_result_type expected_results [$];
   int unsigned        mismatch_count = 0;

   function automatic logic [CELL_W-1:0] blank_cell();
      return {text_attr, CHAR_SPACE};
   endfunction

   task automatic fill_screen(input logic [CELL_W-1:0] value);
      for (int i = 0; i < CELLS; i++) begin
         screen_model[i] = value;
      end
   endtask

   // Move to column 0 of the next row, scrolling the screen up at the bottom.
   task automatic advance_row();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
         end
         for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_model[i] = blank_cell();
         end
         cursor_row = ROWS - 1;
      end
   endtask

   task automatic put_character(input logic [CHAR_W-1:0] code);
      int unsigned here;
      here = cursor_row * COLUMNS + cursor_col;
      if (code == CHAR_BACKSPACE) begin
         // Refused at the left edge and at the guarded prompt column.
         if (cursor_col != 0 && cursor_col != guard_col) begin
            screen_model[here - 1] = blank_cell();
            cursor_col--;
         end
      end else if (code == CHAR_TAB) begin
         cursor_col = cursor_col + TAB_STOP - (cursor_col % TAB_STOP);
      end else if (code == CHAR_CR) begin
         cursor_col = 0;
      end else if (code == CHAR_LF) begin
         advance_row();
      end else if (code >= CHAR_SPACE) begin
         screen_model[here] = {text_attr, code};
         cursor_col++;
      end
      if (cursor_col >= COLUMNS) begin
         advance_row();
      end
   endtask

   // Apply one request to the shadow state and queue the response it must produce.
   task automatic predict_request(input logic [OP_W-1:0]   op,
                                  input logic [CHAR_W-1:0] code,
                                  input logic [IDX_W-1:0]  idx);
      console_result_type res;
      res.value = '0;
      case (op)
         OP_PUT: begin
            put_character(code);
         end
         OP_READ: begin
            if (idx < CELLS) begin
               res.value = screen_model[idx];
            end
         end
         OP_CLEAR: begin
            fill_screen(blank_cell());
            cursor_col = 0;
            cursor_row = 0;
         end
         default: begin
         end
      endcase
      res.position = POS_W'(cursor_row * COLUMNS + cursor_col);
      expected_results.push_back(res);
   endtask

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
   endtask

   // Register writes, response comparison and request prediction, all on the clock edge.
   always @(posedge clock) begin
      console_result_type oldest;
      if (reset) begin
         text_attr  = RESET_ATTRIBUTE;
         guard_col  = RESET_PROTECTED;
         cursor_col = 0;
         cursor_row = 0;
         fill_screen({RESET_ATTRIBUTE, CHAR_SPACE});
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_ATTRIBUTE) begin
               text_attr = csr_write_data[ATTR_W-1:0];
            end else if (csr_index == CSR_PROTECTED) begin
               guard_col = csr_write_data[PCOL_W-1:0];
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected response, cursor_position", 0,
                             rsp_mon.cursor_position);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_mon.cursor_position !== oldest.position) begin
                  note_mismatch("cursor_position", oldest.position, rsp_mon.cursor_position);
               end
               if (rsp_mon.cell_value !== oldest.value) begin
                  note_mismatch("cell_value", oldest.value, rsp_mon.cell_value);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.operation, req_mon.char_code, req_mon.cell_index);
         end
      end
      pending_results <= expected_results.size();
      failures        <= mismatch_count;
   end

endmodule

/* tb/tb_text_console_cursor_engine.sv */
// Top of the text console testbench: clock, reset, request and register stimulus, verdict.
// Depends on tcon_pkg, tcon_req_if, tcon_rsp_if, text_console_cursor_engine and tcon_checker.

module tb_text_console_cursor_engine;
   import tcon_pkg::*;

   localparam int COLUMNS      = COLUMNS_DEF;
   localparam int ROWS         = ROWS_DEF;
   localparam int CELLS        = COLUMNS * ROWS;
   // Longest background job is a full clear; give it room before a register write.
   localparam int SETTLE       = CELLS + COLUMNS + 16;
   localparam int LIMIT_CYCLES = 3000000;
   localparam int PHASE_ITEMS  = 320;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ATTRIBUTE;
   logic [CSR_DAT_W-1:0] csr_write_data = '0;

   logic        rsp_ready = 1'b0;
   int unsigned stall_left = 0;
   int unsigned rsp_mode = 1;
   int unsigned cycle_count = 0;
   int unsigned pending_results;
   int unsigned failures;

   // Sender pacing and bookkeeping.
   int unsigned       items_sent = 0;
   int unsigned       burst_left = 0;
   bit                steady = 1'b1;
   logic [PCOL_W-1:0] guard_setting = RESET_PROTECTED;

   tcon_req_if req_bus ();
   tcon_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready;

   text_console_cursor_engine DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tcon_checker console_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .failures         (failures)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side stalls in runs whose density depends on the current mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         case (rsp_mode)
            1: begin
               if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 4);
            end
            2: begin
               if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 12);
            end
            default: begin
            end
         endcase
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("text_console_cursor_engine verification failed");
         $finish;
      end
   end

   function automatic logic [IDX_W-1:0] any_index();
      return IDX_W'($urandom_range(0, 2047));
   endfunction

   function automatic logic [CHAR_W-1:0] printable_char();
      return CHAR_W'($urandom_range(8'h20, 8'h7E));
   endfunction

   // Offer one request and hold it until it is taken; gaps come between bursts unless steady is set.
   task automatic send_request(input logic [OP_W-1:0]   op,
                               input logic [CHAR_W-1:0] code,
                               input logic [IDX_W-1:0]  idx);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.char_code  <= code;
      req_bus.cell_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] code);
      send_request(OP_PUT, code, any_index());
   endtask

   // Hold off until every response is in, let background work finish, then write registers.
   task automatic reconfigure(input logic [ATTR_W-1:0] attr, input logic [CSR_DAT_W-1:0] guard);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ATTRIBUTE;
      csr_write_data   <= attr;
      @(posedge clock);
      csr_index        <= CSR_PROTECTED;
      csr_write_data   <= guard;
      guard_setting     = guard[PCOL_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One weighted random request of any kind.
   task automatic send_random_item();
      int unsigned r;
      r = $urandom_range(0, 199);
      if (r < 110)      put_char(printable_char());
      else if (r < 122) put_char(CHAR_W'($urandom_range(8'h80, 8'hFF)));
      else if (r < 136) put_char(CHAR_BACKSPACE);
      else if (r < 146) put_char(CHAR_TAB);
      else if (r < 152) put_char(CHAR_CR);
      else if (r < 162) put_char(CHAR_LF);
      else if (r < 167) put_char(CHAR_W'($urandom_range(0, 8'h1F)));
      else if (r < 192) begin
         if ($urandom_range(0, 7) == 0) begin
            send_request(OP_READ, CHAR_W'($urandom), any_index());
         end else begin
            send_request(OP_READ, CHAR_W'($urandom), IDX_W'($urandom_range(0, CELLS - 1)));
         end
      end
      else if (r < 196) send_request(OP_UNUSED, CHAR_W'($urandom), any_index());
      else if (r < 197) send_request(OP_CLEAR, CHAR_W'($urandom), any_index());
      else              put_char(CHAR_W'($urandom_range(0, 255)));
   endtask

   // Mostly single random requests, with typed prompt edits, line feed runs and tab runs between.
   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      int unsigned r;
      int unsigned k;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            put_char(CHAR_CR);
            k = $urandom_range(0, (guard_setting < COLUMNS) ? guard_setting + 2 : 12);
            repeat (k) put_char(printable_char());
            repeat ($urandom_range(1, 4)) put_char(CHAR_BACKSPACE);
         end else if (r < 12) begin
            repeat ($urandom_range(1, 30)) put_char(CHAR_LF);
         end else if (r < 15) begin
            put_char(CHAR_CR);
            repeat ($urandom_range(8, 11)) put_char(CHAR_TAB);
         end else begin
            send_random_item();
         end
      end
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_PUT;
      req_bus.char_code  <= '0;
      req_bus.cell_index <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset contents, out-of-range read, unused operation, left-edge backspace.
      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_READ, 8'hFF, IDX_W'(CELLS - 1));
      send_request(OP_READ, 8'h00, 11'h7FF);
      send_request(OP_UNUSED, 8'hFF, 11'h7FF);
      put_char(CHAR_BACKSPACE);
      put_char(8'h41);
      send_request(OP_READ, 8'h00, 11'd0);
      put_char(CHAR_SPACE);
      put_char(8'hFF);
      put_char(8'h00);
      put_char(8'h1F);
      // Reach the guarded column, where backspace is refused, then type past it and erase back to it.
      put_char(CHAR_TAB);
      put_char(8'h78);
      put_char(8'h79);
      put_char(CHAR_BACKSPACE);
      put_char(8'h7A);
      put_char(CHAR_BACKSPACE);
      send_request(OP_READ, 8'h00, 11'd10);
      put_char(CHAR_CR);
      put_char(CHAR_LF);
      send_request(OP_CLEAR, 8'h00, 11'd0);
      send_request(OP_READ, 8'h00, 11'd10);

      // Full attribute, guard at column 0, no idling on either side.
      rsp_mode <= 0;
      reconfigure(8'hFF, 8'd0);
      put_char(8'h7E);
      put_char(CHAR_BACKSPACE);
      send_request(OP_READ, 8'h00, 11'd0);
      run_random(PHASE_ITEMS);

      steady = 1'b0;
      rsp_mode <= 1;
      reconfigure(8'h00, 8'd79);
      run_random(PHASE_ITEMS);

      // Guard outside the screen.
      rsp_mode <= 2;
      reconfigure(ATTR_W'($urandom), 8'd127);
      run_random(PHASE_ITEMS);

      rsp_mode <= 1;
      reconfigure(ATTR_W'($urandom), CSR_DAT_W'($urandom_range(1, COLUMNS - 1)));
      run_random(PHASE_ITEMS);

      rsp_mode <= 2;
      reconfigure(ATTR_W'($urandom), CSR_DAT_W'($urandom_range(0, 255)));
      run_random(PHASE_ITEMS);

      rsp_mode <= 1;
      reconfigure(RESET_ATTRIBUTE, CSR_DAT_W'(RESET_PROTECTED));
      run_random(PHASE_ITEMS);

      // Drain and give any stray response time to show up.
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("text_console_cursor_engine verification clean");
      end else begin
         $display("text_console_cursor_engine verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/tcon_pkg.sv
sv/tcon_req_if.sv
sv/tcon_rsp_if.sv
sv/tcon_ram.sv
sv/tcon_front.sv
sv/tcon_queue.sv
sv/tcon_back.sv
sv/text_console_cursor_engine.sv
sv/tcon_checker.sv
tb/tcon_checker.sv
tb/tb_text_console_cursor_engine.sv
